// ===== rtl/energy_aware_best_fit_host_select_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the host select core
// Concurrent checks on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ENERGY_AWARE_BEST_FIT_HOST_SELECT_CORE_MACROS_SVH
`define ENERGY_AWARE_BEST_FIT_HOST_SELECT_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define EABF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("host select check failed");
`define EABF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("host select check failed");
`else
`define EABF_ASSERT_SAME(label, ante, cons)
`define EABF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/eabf_pkg.sv =====
// ----------------------------------------------------------------------------
// eabf_pkg
// Types and constants shared by the host select core.
// ----------------------------------------------------------------------------
package eabf_pkg;

    localparam int unsigned MAX_HOSTS_DEF = 1024;
    localparam int unsigned IDX_W         = 10;
    localparam int unsigned NUM_W         = 26;
    localparam int unsigned Q_DEPTH       = 2;

    typedef struct packed {
        logic [7:0]  request_cores;
        logic [23:0] request_ram_mb;
        logic [7:0]  host_free_cores;
        logic [7:0]  host_total_cores;
        logic [23:0] host_free_ram_mb;
        logic [15:0] host_idle_power;
        logic [15:0] host_peak_power;
        logic        host_was_used;
        logic        last_host;
    } t_in;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] host_index;
        logic             chosen_was_active;
    } t_out;

    // classified host record, front to back
    typedef struct packed {
        logic                    fits;
        logic                    used;
        logic                    last;
        logic [IDX_W-1:0]        idx;
        logic signed [NUM_W-1:0] num;
        logic [7:0]              total;
        logic [7:0]              spare_cores;
        logic [23:0]             spare_ram;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/energy_aware_best_fit_host_select_core.sv =====
// ----------------------------------------------------------------------------
// energy_aware_best_fit_host_select_core
// Energy-aware best-fit host selection for one VM request per scan.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one host record
//   per beat; every beat repeats the VM request. last_host closes a scan.
//   Output channel (o_out_valid / i_out_ready / o_out_data) gives one beat per
//   scan: found, chosen host position, and whether it was an active host.
//   Throughput: one host record per cycle while the queue is not full. The
//   front classifies a record in the cycle it is accepted (fit check,
//   (peak-idle)*cores product) and writes it into a two-entry queue; the back
//   retires one queued record per cycle unless it holds a last_host record for
//   a waiting result, its limit being the cross-multiply compare against the
//   running best. A last_host record passes through the queue, then sets the
//   registered result beat. Output stall: the back keeps retiring records
//   while a result waits; a second last_host record waits at the queue head,
//   with any records behind it, and once the queue fills o_in_ready drops.
//   Reset (synchronous, i_rst_n low): scan position, running bests, queue and
//   output valid are cleared; the block is ready the cycle after release.
// ----------------------------------------------------------------------------
module energy_aware_best_fit_host_select_core #(
    parameter int unsigned MAX_HOSTS = eabf_pkg::MAX_HOSTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  eabf_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output eabf_pkg::t_out o_out_data
);

`include "energy_aware_best_fit_host_select_core_macros.svh"

    logic              w_push;
    logic              w_pop;
    eabf_pkg::t_job    w_front_job;
    eabf_pkg::t_job    w_head_job;
    eabf_pkg::t_q_stat w_q_stat;

    // front: fit check, increase numerator, spares, scan position
    eabf_front #(
        .MAX_HOSTS (MAX_HOSTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_job      (w_front_job)
    );

    // decoupling queue
    eabf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_stat  (w_q_stat)
    );

    // back: running best, result register
    eabf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_head_job),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // a result only ever follows retirement of a last_host record
    `EABF_ASSERT_SAME(a_result_source, $rose(o_out_valid), $past(w_pop && w_head_job.last))
    // no fit means index zero and not active
    `EABF_ASSERT_SAME(a_none_found, o_out_valid && !o_out_data.found,
                      o_out_data.host_index == '0 && !o_out_data.chosen_was_active)
    // the back never retires from an empty queue
    `EABF_ASSERT_SAME(a_pop_nonempty, w_pop, !w_q_stat.empty)
    // a pushed record leaves the queue non-empty
    `EABF_ASSERT_NEXT(a_push_lands, w_push && !w_pop, !w_q_stat.empty)

endmodule

// ===== rtl/eabf_front.sv =====
// ----------------------------------------------------------------------------
// eabf_front
// Takes host records, checks fit, forms the power increase and spares.
// ----------------------------------------------------------------------------
module eabf_front #(
    parameter int unsigned MAX_HOSTS = eabf_pkg::MAX_HOSTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  eabf_pkg::t_in    i_in_data,
    input  eabf_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output eabf_pkg::t_job   o_job
);

    localparam int unsigned PosW = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;

    logic [PosW-1:0]  r_pos;
    logic [PosW-1:0]  n_pos;
    logic signed [16:0] w_diff;
    logic signed [8:0]  w_rc;
    logic signed [25:0] w_num;

    assign o_in_ready = !i_q_stat.full;
    assign o_push     = i_in_valid && o_in_ready;

    assign w_diff = $signed({1'b0, i_in_data.host_peak_power})
                  - $signed({1'b0, i_in_data.host_idle_power});
    assign w_rc   = $signed({1'b0, i_in_data.request_cores});
    assign w_num  = w_diff * w_rc;

    always_comb begin
        o_job.fits = (i_in_data.host_free_cores >= i_in_data.request_cores) &&
                     (i_in_data.host_free_ram_mb >= i_in_data.request_ram_mb);
        o_job.used = i_in_data.host_was_used;
        o_job.last = i_in_data.last_host;
        o_job.idx  = eabf_pkg::IDX_W'(r_pos);
        o_job.num  = w_num;
        // zero total cores counts as one
        o_job.total = (i_in_data.host_total_cores == 8'd0) ? 8'd1
                                                           : i_in_data.host_total_cores;
        o_job.spare_cores = i_in_data.host_free_cores - i_in_data.request_cores;
        o_job.spare_ram   = i_in_data.host_free_ram_mb - i_in_data.request_ram_mb;
    end

    always_comb begin
        n_pos = r_pos;
        if (o_push) begin
            if (i_in_data.last_host || r_pos == PosW'(MAX_HOSTS - 1)) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + PosW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// ===== rtl/eabf_queue.sv =====
// ----------------------------------------------------------------------------
// eabf_queue
// Short register FIFO of classified records between front and back.
// ----------------------------------------------------------------------------
module eabf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  eabf_pkg::t_job    i_job,
    input  logic              i_pop,
    output eabf_pkg::t_job    o_job,
    output eabf_pkg::t_q_stat o_stat
);

    localparam int unsigned PtrW = (eabf_pkg::Q_DEPTH > 1) ? $clog2(eabf_pkg::Q_DEPTH) : 1;
    localparam int unsigned CntW = $clog2(eabf_pkg::Q_DEPTH + 1);

    eabf_pkg::t_job r_mem [eabf_pkg::Q_DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;
    logic [PtrW-1:0] n_wr;
    logic [PtrW-1:0] n_rd;
    logic [CntW-1:0] n_cnt;

    assign o_stat.full  = (r_cnt == CntW'(eabf_pkg::Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_job        = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PtrW'(eabf_pkg::Q_DEPTH - 1)) ? '0 : r_wr + PtrW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrW'(eabf_pkg::Q_DEPTH - 1)) ? '0 : r_rd + PtrW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CntW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== rtl/eabf_back.sv =====
// ----------------------------------------------------------------------------
// eabf_back
// Keeps the running best used and unused host, issues the scan result.
// ----------------------------------------------------------------------------
module eabf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  eabf_pkg::t_job    i_job,
    input  eabf_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output eabf_pkg::t_out    o_out_data
);

    localparam int unsigned PW = eabf_pkg::NUM_W + 9;

    logic                             r_a_found, n_a_found;
    logic [eabf_pkg::IDX_W-1:0]       r_a_idx,   n_a_idx;
    logic signed [eabf_pkg::NUM_W-1:0] r_a_num,  n_a_num;
    logic [7:0]                       r_a_tot,   n_a_tot;
    logic [7:0]                       r_a_sc,    n_a_sc;
    logic [23:0]                      r_a_sr,    n_a_sr;
    logic                             r_f_found, n_f_found;
    logic [eabf_pkg::IDX_W-1:0]       r_f_idx,   n_f_idx;
    logic signed [eabf_pkg::NUM_W-1:0] r_f_num,  n_f_num;
    logic [7:0]                       r_f_tot,   n_f_tot;
    logic                             r_out_valid, n_out_valid;
    eabf_pkg::t_out                   r_out, n_out;

    logic signed [PW-1:0] w_num_x, w_a_num_x, w_f_num_x;
    logic signed [PW-1:0] w_tot_x, w_a_tot_x, w_f_tot_x;
    logic signed [PW-1:0] w_a_l, w_a_r, w_f_l, w_f_r;
    logic                 w_take_a, w_take_f;

    assign o_pop = !i_q_stat.empty && (!i_job.last || !r_out_valid || i_out_ready);

    assign w_num_x   = PW'(i_job.num);
    assign w_a_num_x = PW'(r_a_num);
    assign w_f_num_x = PW'(r_f_num);
    assign w_tot_x   = $signed(PW'(i_job.total));
    assign w_a_tot_x = $signed(PW'(r_a_tot));
    assign w_f_tot_x = $signed(PW'(r_f_tot));

    // cross-multiplied increase compare
    assign w_a_l = w_num_x * w_a_tot_x;
    assign w_a_r = w_a_num_x * w_tot_x;
    assign w_f_l = w_num_x * w_f_tot_x;
    assign w_f_r = w_f_num_x * w_tot_x;

    assign w_take_a = !r_a_found || (w_a_l < w_a_r) ||
                      ((w_a_l == w_a_r) &&
                       ((i_job.spare_cores < r_a_sc) ||
                        ((i_job.spare_cores == r_a_sc) && (i_job.spare_ram < r_a_sr))));
    assign w_take_f = !r_f_found || (w_f_l < w_f_r);

    always_comb begin
        n_a_found   = r_a_found;
        n_a_idx     = r_a_idx;
        n_a_num     = r_a_num;
        n_a_tot     = r_a_tot;
        n_a_sc      = r_a_sc;
        n_a_sr      = r_a_sr;
        n_f_found   = r_f_found;
        n_f_idx     = r_f_idx;
        n_f_num     = r_f_num;
        n_f_tot     = r_f_tot;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        if (o_pop && i_job.fits) begin
            if (i_job.used && w_take_a) begin
                n_a_found = 1'b1;
                n_a_idx   = i_job.idx;
                n_a_num   = i_job.num;
                n_a_tot   = i_job.total;
                n_a_sc    = i_job.spare_cores;
                n_a_sr    = i_job.spare_ram;
            end else if (!i_job.used && w_take_f) begin
                n_f_found = 1'b1;
                n_f_idx   = i_job.idx;
                n_f_num   = i_job.num;
                n_f_tot   = i_job.total;
            end
        end

        if (o_pop && i_job.last) begin
            n_out_valid = 1'b1;
            if (n_a_found) begin
                n_out.found             = 1'b1;
                n_out.host_index        = n_a_idx;
                n_out.chosen_was_active = 1'b1;
            end else if (n_f_found) begin
                n_out.found             = 1'b1;
                n_out.host_index        = n_f_idx;
                n_out.chosen_was_active = 1'b0;
            end else begin
                n_out.found             = 1'b0;
                n_out.host_index        = '0;
                n_out.chosen_was_active = 1'b0;
            end
            // scan done: back to reset values
            n_a_found = 1'b0;
            n_a_idx   = '0;
            n_a_num   = '0;
            n_a_tot   = 8'd1;
            n_a_sc    = '0;
            n_a_sr    = '0;
            n_f_found = 1'b0;
            n_f_idx   = '0;
            n_f_num   = '0;
            n_f_tot   = 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_found   <= 1'b0;
            r_a_idx     <= '0;
            r_a_num     <= '0;
            r_a_tot     <= 8'd1;
            r_a_sc      <= '0;
            r_a_sr      <= '0;
            r_f_found   <= 1'b0;
            r_f_idx     <= '0;
            r_f_num     <= '0;
            r_f_tot     <= 8'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_a_found   <= n_a_found;
            r_a_idx     <= n_a_idx;
            r_a_num     <= n_a_num;
            r_a_tot     <= n_a_tot;
            r_a_sc      <= n_a_sc;
            r_a_sr      <= n_a_sr;
            r_f_found   <= n_f_found;
            r_f_idx     <= n_f_idx;
            r_f_num     <= n_f_num;
            r_f_tot     <= n_f_tot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the energy-aware best-fit host select core. Host
// records stream in as scans; a placement model in the bench predicts the
// chosen host of every scan, and each result beat is compared field by field.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [23:0] RAM_MAX  = 24'hFFFFFF;
    localparam int unsigned DRAIN_MAX = 20000;  // cycles allowed for the final drain

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic           i_clk     = 1'b0;
    logic           i_rst_n   = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    eabf_pkg::t_in  in_data   = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    eabf_pkg::t_out out_data;

    always #5 i_clk = ~i_clk;

    energy_aware_best_fit_host_select_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // ------------------------------------------------------------------------
    // Placement model: running bests over used ("active") and unused
    // ("fresh") hosts, cleared at every scan end. Increases are kept as
    // numerator / total pairs and compared by cross-multiplying.
    // ------------------------------------------------------------------------
    logic [eabf_pkg::IDX_W-1:0] scan_pos;
    bit                         act_found;
    logic [eabf_pkg::IDX_W-1:0] act_idx;
    longint                     act_num;
    longint                     act_tot;
    int unsigned                act_spare_c;
    int unsigned                act_spare_r;
    bit                         fresh_found;
    logic [eabf_pkg::IDX_W-1:0] fresh_idx;
    longint                     fresh_num;
    longint                     fresh_tot;

    eabf_pkg::t_out placement_q[$];   // predicted choices, oldest first

    int unsigned mismatch_cnt  = 0;
    int unsigned beats_sent    = 0;
    int unsigned scans_checked = 0;

    task automatic restart_scan();
        scan_pos    = '0;
        act_found   = 1'b0;
        act_idx     = '0;
        act_num     = 0;
        act_tot     = 1;
        act_spare_c = 0;
        act_spare_r = 0;
        fresh_found = 1'b0;
        fresh_idx   = '0;
        fresh_num   = 0;
        fresh_tot   = 1;
    endtask

    // -1 / 0 / 1 as a/ta is below, equal to, above b/tb (totals positive)
    function automatic int cmp_rise(longint a, longint ta, longint b, longint tb);
        longint lhs;
        longint rhs;
        lhs = a * tb;
        rhs = b * ta;
        if (lhs < rhs) return -1;
        if (lhs > rhs) return 1;
        return 0;
    endfunction

    task automatic place_vm(input eabf_pkg::t_in rec);
        longint         tot;
        longint         num;
        int unsigned    spare_c;
        int unsigned    spare_r;
        int             c;
        bit             take;
        eabf_pkg::t_out res;
        // zero total cores counts as one
        tot = (rec.host_total_cores == 8'd0) ? 1 : longint'(rec.host_total_cores);
        if (rec.host_free_cores >= rec.request_cores &&
            rec.host_free_ram_mb >= rec.request_ram_mb) begin
            // signed: peak below idle gives a negative increase
            num = (longint'(rec.host_peak_power) - longint'(rec.host_idle_power)) *
                  longint'(rec.request_cores);
            spare_c = 32'(8'(rec.host_free_cores - rec.request_cores));
            spare_r = 32'(24'(rec.host_free_ram_mb - rec.request_ram_mb));
            if (rec.host_was_used) begin
                take = !act_found;
                if (!take) begin
                    c = cmp_rise(num, tot, act_num, act_tot);
                    take = (c < 0) ||
                           (c == 0 && (spare_c < act_spare_c ||
                                       (spare_c == act_spare_c && spare_r < act_spare_r)));
                end
                if (take) begin
                    act_found   = 1'b1;
                    act_idx     = scan_pos;
                    act_num     = num;
                    act_tot     = tot;
                    act_spare_c = spare_c;
                    act_spare_r = spare_r;
                end
            end else if (!fresh_found || cmp_rise(num, tot, fresh_num, fresh_tot) < 0) begin
                fresh_found = 1'b1;
                fresh_idx   = scan_pos;
                fresh_num   = num;
                fresh_tot   = tot;
            end
        end
        scan_pos = scan_pos + 1'b1;   // wraps at 1024
        if (rec.last_host) begin
            res = '0;
            if (act_found) begin
                res.found             = 1'b1;
                res.host_index        = act_idx;
                res.chosen_was_active = 1'b1;
            end else if (fresh_found) begin
                res.found      = 1'b1;
                res.host_index = fresh_idx;
            end
            placement_q.push_back(res);
            restart_scan();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every accepted output beat against the oldest
    // prediction. First ten problems are printed, the rest only counted.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        eabf_pkg::t_out want;
        if (i_rst_n && out_valid && out_ready) begin
            scans_checked++;
            if (placement_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("[%0t] unexpected result beat: found=%0b idx=%0d active=%0b",
                             $realtime, out_data.found, out_data.host_index,
                             out_data.chosen_was_active);
            end else begin
                want = placement_q.pop_front();
                if (out_data.found !== want.found ||
                    out_data.host_index !== want.host_index ||
                    out_data.chosen_was_active !== want.chosen_was_active) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("[%0t] result mismatch: exp found=%0b idx=%0d active=%0b",
                                 $realtime, want.found, want.host_index,
                                 want.chosen_was_active);
                        $display("    got found=%0b idx=%0d active=%0b",
                                 out_data.found, out_data.host_index,
                                 out_data.chosen_was_active);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: alternating ready / stall runs of random length. A test can
    // request a long hold-off by bumping hold_seq; it is counted down here.
    // ------------------------------------------------------------------------
    bit          rx_stalls = 1'b1;
    int unsigned hold_len  = 0;
    int unsigned hold_seq  = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned run_left  = 0;
    bit          run_ready = 1'b0;

    always @(posedge i_clk) begin : rx_pattern
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (!rx_stalls) begin
            out_ready <= 1'b1;
        end else begin
            if (run_left == 0) begin
                run_ready = !run_ready;
                run_left  = run_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
            end
            run_left--;
            out_ready <= run_ready;
        end
    end

    // ------------------------------------------------------------------------
    // Sender: one host record per call. With tx_idles set, records go out in
    // bursts with random gaps between them. The model sees the record at the
    // edge where it is accepted.
    // ------------------------------------------------------------------------
    bit          tx_idles   = 1'b1;
    int unsigned burst_left = 0;

    task automatic send_host(input eabf_pkg::t_in rec);
        if (tx_idles && burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left != 0)
            burst_left--;
        in_valid <= 1'b1;
        in_data  <= rec;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        place_vm(rec);
        beats_sent++;
    endtask

    // sender pause: nothing offered until every predicted result has come
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (placement_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic eabf_pkg::t_in host_rec(input logic [7:0] rc, input logic [23:0] rr,
                                               input logic [7:0] fc, input logic [7:0] tc,
                                               input logic [23:0] fr,
                                               input logic [15:0] idle,
                                               input logic [15:0] peak, input bit used,
                                               input bit last);
        eabf_pkg::t_in rec;
        rec.request_cores    = rc;
        rec.request_ram_mb   = rr;
        rec.host_free_cores  = fc;
        rec.host_total_cores = tc;
        rec.host_free_ram_mb = fr;
        rec.host_idle_power  = idle;
        rec.host_peak_power  = peak;
        rec.host_was_used    = used;
        rec.last_host        = last;
        return rec;
    endfunction

    // powers: half from a small pool so that equal increases are common
    function automatic logic [15:0] pick_power(input bit is_peak);
        if ($urandom_range(0, 1))
            return 16'($urandom);
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return is_peak ? 16'd320 : 16'd160;
            2:       return is_peak ? 16'd640 : 16'd320;
            default: return is_peak ? 16'd1280 : 16'd0;
        endcase
    endfunction

    // One scan of n records with random content. A steady scan keeps the
    // request for all of its records; otherwise it changes now and then.
    task automatic send_random_scan(input int unsigned n, input bit steady);
        eabf_pkg::t_in rec;
        logic [7:0]    rc;
        logic [23:0]   rr;
        for (int unsigned i = 0; i < n; i++) begin
            if (i == 0 || (!steady && $urandom_range(0, 3) == 0)) begin
                case ($urandom_range(0, 3))
                    0:       rc = 8'($urandom_range(0, 4));
                    1:       rc = 8'($urandom_range(0, 32));
                    default: rc = 8'($urandom_range(0, 255));
                endcase
                case ($urandom_range(0, 2))
                    0:       rr = 24'($urandom_range(0, 4096));
                    1:       rr = 24'($urandom_range(0, 1 << 20));
                    default: rr = 24'($urandom);
                endcase
            end
            rec = '0;
            rec.request_cores  = rc;
            rec.request_ram_mb = rr;
            // mostly fitting hosts, some short on cores or on RAM
            if ($urandom_range(0, 3) != 0 || rc == 8'd0)
                rec.host_free_cores = 8'(rc + $urandom_range(0, 255 - rc));
            else
                rec.host_free_cores = 8'($urandom_range(0, rc - 1));
            if ($urandom_range(0, 7) != 0 || rr == 24'd0)
                rec.host_free_ram_mb = 24'(rr + $urandom_range(0, RAM_MAX - rr));
            else
                rec.host_free_ram_mb = 24'($urandom_range(0, rr - 1));
            case ($urandom_range(0, 15))
                0:       rec.host_total_cores = 8'd0;
                1, 2, 3: rec.host_total_cores = 8'd1 << $urandom_range(0, 3);
                default: rec.host_total_cores = 8'($urandom_range(1, 255));
            endcase
            rec.host_idle_power = pick_power(1'b0);
            rec.host_peak_power = pick_power(1'b1);
            rec.host_was_used   = 1'($urandom_range(0, 1));
            rec.last_host       = (i == n - 1);
            send_host(rec);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // single-record scans at the edges of every field
    task automatic test_field_extremes();
        // all zero: zero request fits a host with nothing free
        send_host(host_rec(8'd0, 24'd0, 8'd0, 8'd0, 24'd0, 16'd0, 16'd0, 1'b0, 1'b1));
        send_host(host_rec(8'd0, 24'd0, 8'd0, 8'd1, 24'd0, 16'd0, 16'd0, 1'b1, 1'b1));
        // everything at its maximum, exact fit
        send_host(host_rec(8'hFF, RAM_MAX, 8'hFF, 8'hFF, RAM_MAX, 16'hFFFF, 16'hFFFF,
                           1'b1, 1'b1));
        // one core short, then one MB short: no host fits
        send_host(host_rec(8'hFF, 24'd0, 8'hFE, 8'hFF, RAM_MAX, 16'd0, 16'hFFFF, 1'b1, 1'b1));
        send_host(host_rec(8'd1, RAM_MAX, 8'hFF, 8'd4, 24'hFFFFFE, 16'd0, 16'd16, 1'b0, 1'b1));
        // zero total cores with the most negative increase
        send_host(host_rec(8'hFF, 24'd1, 8'hFF, 8'd0, 24'd1, 16'hFFFF, 16'd0, 1'b0, 1'b1));
        wait_for_results();
    endtask

    // ordering among equal increases, and used hosts ahead of unused ones
    task automatic test_tie_breaks();
        // used hosts, all at increase 80: fewer spare cores wins, then less
        // spare RAM; an exact repeat keeps the earlier host. The unused host
        // with zero increase loses to any fitting used host.
        send_host(host_rec(8'd2, 24'd100, 8'd4, 8'd4, 24'd200, 16'd0, 16'd160, 1'b1, 1'b0));
        send_host(host_rec(8'd2, 24'd100, 8'd3, 8'd8, 24'd200, 16'd0, 16'd320, 1'b1, 1'b0));
        send_host(host_rec(8'd2, 24'd100, 8'd3, 8'd2, 24'd150, 16'd100, 16'd180, 1'b1, 1'b0));
        send_host(host_rec(8'd2, 24'd100, 8'd3, 8'd2, 24'd150, 16'd100, 16'd180, 1'b1, 1'b0));
        send_host(host_rec(8'd2, 24'd100, 8'd9, 8'd9, 24'd999, 16'd0, 16'd0, 1'b0, 1'b1));
        // no used host fits; unused ones: equal increase over another total
        // keeps the first, a negative increase (peak below idle) wins, its
        // repeat does not. Free cores above total are taken as they are.
        send_host(host_rec(8'd2, 24'd100, 8'd1, 8'd4, 24'd500, 16'd0, 16'd0, 1'b1, 1'b0));
        send_host(host_rec(8'd2, 24'd100, 8'd200, 8'd4, 24'd500, 16'd0, 16'd160, 1'b0, 1'b0));
        send_host(host_rec(8'd2, 24'd100, 8'd8, 8'd8, 24'd500, 16'd0, 16'd320, 1'b0, 1'b0));
        send_host(host_rec(8'd2, 24'd100, 8'd8, 8'd8, 24'd500, 16'd500, 16'd100, 1'b0, 1'b0));
        send_host(host_rec(8'd2, 24'd100, 8'd8, 8'd8, 24'd500, 16'd500, 16'd100, 1'b0, 1'b1));
        wait_for_results();
    endtask

    // every record is judged with the request that it carries
    task automatic test_request_change();
        send_host(host_rec(8'd8, 24'd10, 8'd4, 8'd4, 24'd10, 16'd0, 16'd16, 1'b1, 1'b0));
        send_host(host_rec(8'd2, 24'd10, 8'd4, 8'd4, 24'd10, 16'd0, 16'd16, 1'b1, 1'b0));
        send_host(host_rec(8'd0, 24'd20, 8'd4, 8'd4, 24'd10, 16'd0, 16'd16, 1'b0, 1'b1));
        wait_for_results();
    endtask

    // Scan longer than the position counter: the winner sits at record 1027
    // and must be reported at position 3; all others but record 5 miss on cores.
    task automatic test_index_wrap();
        eabf_pkg::t_in rec;
        for (int unsigned i = 0; i < 1030; i++) begin
            rec = host_rec(8'd1, 24'($urandom), 8'd0, 8'($urandom), 24'($urandom),
                           16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                           i == 1029);
            if (i == 5)
                rec = host_rec(8'd1, 24'd0, 8'd4, 8'd1, 24'd0, 16'd0, 16'd1000, 1'b0, 1'b0);
            if (i == 1027)
                rec = host_rec(8'd1, 24'd0, 8'd4, 8'd1, 24'd0, 16'd0, 16'd10, 1'b0, 1'b0);
            send_host(rec);
        end
        wait_for_results();
    endtask

    // Output held off for a long stretch while short scans keep coming:
    // the queue fills and the input must stall without losing anything.
    task automatic test_output_hold();
        tx_idles = 1'b0;
        hold_len = 300;
        hold_seq++;
        for (int unsigned s = 0; s < 40; s++)
            send_random_scan($urandom_range(1, 3), 1'b1);
        wait_for_results();
        tx_idles = 1'b1;
    endtask

    // random scans, mostly short with a steady request
    task automatic test_random_scans(input int unsigned n_items, input bit tx_gap,
                                     input bit rx_gap);
        int unsigned first;
        int unsigned pick;
        int unsigned len;
        tx_idles = tx_gap;
        rx_stalls = rx_gap;
        first = beats_sent;
        while (beats_sent - first < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                len = $urandom_range(1, 10);
            else if (pick < 95)
                len = $urandom_range(11, 40);
            else
                len = $urandom_range(41, 120);
            send_random_scan(len, $urandom_range(0, 9) != 0);
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int unsigned waited;
        restart_scan();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_tie_breaks();
        test_request_change();
        test_index_wrap();
        test_output_hold();
        test_random_scans(50, 1'b1, 1'b1);
        test_random_scans(20, 1'b0, 1'b0);   // back to back, no stalls
        test_random_scans(20, 1'b1, 1'b0);
        test_random_scans(20, 1'b0, 1'b1);

        // final drain, bounded; anything still predicted is a failure
        in_valid <= 1'b0;
        waited = 0;
        while (placement_q.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (placement_q.size() != 0) begin
            mismatch_cnt += placement_q.size();
            $display("%0d predicted results never arrived", placement_q.size());
        end

        $display("Streamed %0d host records, %0d scan results checked.",
                 beats_sent, scans_checked);
        $display("Covered field extremes, tie ordering, request changes, index wrap, hold-off.");
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #2ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== energy_aware_best_fit_host_select_core.f =====
+incdir+rtl
rtl/eabf_pkg.sv
rtl/eabf_front.sv
rtl/eabf_queue.sv
rtl/eabf_back.sv
rtl/energy_aware_best_fit_host_select_core.sv
dv/tb.sv
